// ===== hdl/jse_pkg.sv =====
`default_nettype none
package jse_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 3;  // runs are up to six beats long

  localparam logic [ByteW-1:0] ChBslash = 8'h5c;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChLt     = 8'h3c;
  localparam logic [ByteW-1:0] ChGt     = 8'h3e;
  localparam logic [ByteW-1:0] ChAmp    = 8'h26;
  localparam logic [ByteW-1:0] ChNl     = 8'h0a;
  localparam logic [ByteW-1:0] ChCr     = 8'h0d;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChBs     = 8'h08;
  localparam logic [ByteW-1:0] ChFf     = 8'h0c;
  localparam logic [ByteW-1:0] ChLowU   = 8'h75;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] CtrlLimit = 8'h20;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PAIR,
    KIND_UNI
  } kind_t;

  // one output beat of a run
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } beat_t;

  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
    logic [ByteW-1:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h57 + {4'd0, nib};  // 'a' - 10
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/json_string_escaper.sv =====
// JSON string escaper, HTML-safe flavor.
// in_*: one raw string byte per beat on in_tdata.
// out_*: the escaped text, one byte per beat on out_tdata; out_tlast marks
//   the final byte of the run that belongs to one input byte.
// Runs are 1 byte (plain), 2 bytes (backslash pair) or 6 bytes (\u00xx).
// Path: an input byte is held in the byte register, then each beat of its
//   run passes through the output register.
// Throughput: one output beat per cycle while out_tready is high; an input
//   byte holds the byte register until the last beat of its run moves,
//   so plain bytes stream at one per cycle while out_tready is high.
// A new input byte is taken in the same cycle the last beat of the
//   previous run moves into the output register.
// Reset empties both registers; no output beat is pending afterwards.
// When out_tready is low the output beat holds and, once the byte
//   register is busy, in_tready drops.
`default_nettype none
module json_string_escaper (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // last_of_run
);

  logic                        cur_vld_r;
  logic [jse_pkg::ByteW-1:0]   cur_byte_r;
  logic [jse_pkg::IdxW-1:0]    cur_idx_r;
  logic                        out_vld_r;
  logic [jse_pkg::ByteW-1:0]   out_data_r;
  logic                        out_last_r;
  jse_pkg::beat_t              beat;
  logic                        move;

  jse_expand u_expand (
    .raw  (cur_byte_r),
    .idx  (cur_idx_r),
    .beat (beat)
  );

  assign move      = cur_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !cur_vld_r || (move && beat.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      cur_idx_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cur_vld_r  <= 1'b1;
        cur_byte_r <= in_tdata;
        cur_idx_r  <= '0;
      end else if (move) begin
        if (beat.last) begin
          cur_vld_r <= 1'b0;
        end
        cur_idx_r <= cur_idx_r + 3'd1;
      end
      if (move) begin
        out_vld_r  <= 1'b1;
        out_data_r <= beat.data;
        out_last_r <= beat.last;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== hdl/jse_expand.sv =====
`default_nettype none
// Gives beat number idx of the escaped run for one raw byte.
module jse_expand (
  input  wire logic [jse_pkg::ByteW-1:0] raw,
  input  wire logic [jse_pkg::IdxW-1:0]  idx,
  output jse_pkg::beat_t                 beat
);

  jse_pkg::kind_t            kind;
  logic [jse_pkg::ByteW-1:0] second;

  always_comb begin
    kind   = jse_pkg::KIND_PLAIN;
    second = raw;
    case (raw)
      jse_pkg::ChQuote:  kind = jse_pkg::KIND_PAIR;
      jse_pkg::ChBslash: kind = jse_pkg::KIND_PAIR;
      jse_pkg::ChNl: begin
        kind   = jse_pkg::KIND_PAIR;
        second = 8'h6e;  // n
      end
      jse_pkg::ChCr: begin
        kind   = jse_pkg::KIND_PAIR;
        second = 8'h72;  // r
      end
      jse_pkg::ChTab: begin
        kind   = jse_pkg::KIND_PAIR;
        second = 8'h74;  // t
      end
      jse_pkg::ChBs: begin
        kind   = jse_pkg::KIND_PAIR;
        second = 8'h62;  // b
      end
      jse_pkg::ChFf: begin
        kind   = jse_pkg::KIND_PAIR;
        second = 8'h66;  // f
      end
      jse_pkg::ChLt:  kind = jse_pkg::KIND_UNI;
      jse_pkg::ChGt:  kind = jse_pkg::KIND_UNI;
      jse_pkg::ChAmp: kind = jse_pkg::KIND_UNI;
      default: begin
        if (raw < jse_pkg::CtrlLimit) begin
          kind = jse_pkg::KIND_UNI;
        end
      end
    endcase
  end

  always_comb begin
    beat.data = raw;
    beat.last = 1'b1;
    case (kind)
      jse_pkg::KIND_PAIR: begin
        beat.data = (idx == 3'd0) ? jse_pkg::ChBslash : second;
        beat.last = (idx == 3'd1);
      end
      jse_pkg::KIND_UNI: begin
        case (idx)
          3'd0:    beat.data = jse_pkg::ChBslash;
          3'd1:    beat.data = jse_pkg::ChLowU;
          3'd2:    beat.data = jse_pkg::ChZero;
          3'd3:    beat.data = jse_pkg::ChZero;
          3'd4:    beat.data = jse_pkg::hex_digit(raw[7:4]);
          default: beat.data = jse_pkg::hex_digit(raw[3:0]);
        endcase
        beat.last = (idx == 3'd5);
      end
      default: begin
        beat.data = raw;
        beat.last = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire
